### hdl/tkpeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpeq_pkg
// Shared types and constants for the three-key press event qualifier.
// ----------------------------------------------------------------------------
package tkpeq_pkg;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_LONG_PRESS_TICKS = 2'd0;
    localparam cfg_index_t REG_B_GAP_TICKS      = 2'd1;
    localparam cfg_index_t REG_PRESS_LEVEL      = 2'd2;
    localparam cfg_index_t REG_KEY_ENABLE       = 2'd3;

    // Register widths and reset values
    localparam int THRESH_W = 16;
    localparam int KEY_EN_W = 3;

    localparam logic [THRESH_W-1:0] LONG_PRESS_TICKS_RST = 16'd1500;
    localparam logic [THRESH_W-1:0] B_GAP_TICKS_RST      = 16'd220;
    localparam logic                PRESS_LEVEL_RST      = 1'b1;
    localparam logic [KEY_EN_W-1:0] KEY_ENABLE_RST       = 3'd7;

    // Bit positions within key_enable
    localparam int KEY_POWER = 0;
    localparam int KEY_B     = 1;
    localparam int KEY_T     = 2;

    // Live configuration handed to the event logic
    typedef struct packed {
        logic [THRESH_W-1:0] long_press_ticks;
        logic [THRESH_W-1:0] b_gap_ticks;
        logic                press_level;
        logic [KEY_EN_W-1:0] key_enable;
    } tkpeq_cfg_t;

    // One result beat: the event mask
    typedef struct packed {
        logic power_press;
        logic power_short;
        logic power_long;
        logic b_short;
        logic t_short;
    } tkpeq_events_t;

endpackage

### hdl/tkpeq_event_logic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpeq_event_logic
// Per-key state and the single-pass decode of one sample into an event mask.
// State advances on every accepted sample; events are combinational.
// ----------------------------------------------------------------------------
module tkpeq_event_logic
    import tkpeq_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          power_level,
    input  logic          b_level,
    input  logic          t_level,
    input  logic          tick,
    input  tkpeq_cfg_t    cfg,
    output tkpeq_events_t events
);

    // Compare width covers both the counter and the 16-bit thresholds
    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic                   power_pressed_reg,   power_pressed_next;
    logic                   power_long_done_reg, power_long_done_next;
    logic [COUNT_WIDTH-1:0] power_hold_reg,      power_hold_next;
    logic                   t_pressed_reg,       t_pressed_next;
    logic                   b_idle_known_reg,    b_idle_known_next;
    logic                   b_idle_level_reg,    b_idle_level_next;
    logic                   b_pressed_reg,       b_pressed_next;
    logic                   b_short_seen_reg,    b_short_seen_next;
    logic [COUNT_WIDTH-1:0] b_since_reg,         b_since_next;

    logic [COUNT_WIDTH-1:0] hold_inc;
    logic [COUNT_WIDTH-1:0] since_inc;
    logic                   t_active;
    logic                   long_reached;
    logic                   debounce_over;
    logic                   ev_press;
    logic                   ev_short;
    logic                   ev_long;
    logic                   ev_b;
    logic                   ev_t;

    // Saturating increments
    assign hold_inc  = (power_hold_reg == CNT_MAX) ? power_hold_reg
                                                   : power_hold_reg + CNT_ONE;
    assign since_inc = !tick ? b_since_reg
                     : ((b_since_reg == CNT_MAX) ? b_since_reg : b_since_reg + CNT_ONE);

    assign long_reached  = CMP_W'(hold_inc)  >= CMP_W'(cfg.long_press_ticks);
    assign debounce_over = CMP_W'(since_inc) >= CMP_W'(cfg.b_gap_ticks);
    assign t_active      = (t_level == cfg.press_level);

    assign events = {ev_press, ev_short, ev_long, ev_b, ev_t};

    // Power key
    always_comb
    begin
        power_pressed_next   = power_pressed_reg;
        power_long_done_next = power_long_done_reg;
        power_hold_next      = power_hold_reg;
        ev_press             = 1'b0;
        ev_short             = 1'b0;
        ev_long              = 1'b0;
        if (!cfg.key_enable[KEY_POWER])
        begin
            power_pressed_next   = 1'b0;
            power_long_done_next = 1'b0;
            power_hold_next      = '0;
        end
        else if (power_level == cfg.press_level)
        begin
            if (!power_pressed_reg)
            begin
                power_pressed_next   = 1'b1;
                power_long_done_next = 1'b0;
                power_hold_next      = '0;
                ev_press             = 1'b1;
            end
            else if (tick)
            begin
                power_hold_next = hold_inc;
                if (!power_long_done_reg && long_reached)
                begin
                    power_long_done_next = 1'b1;
                    ev_long              = 1'b1;
                end
            end
        end
        else
        begin
            ev_short           = power_pressed_reg && !power_long_done_reg;
            power_pressed_next = 1'b0;
        end
    end

    // T key: press edge only
    always_comb
    begin
        t_pressed_next = 1'b0;
        ev_t           = 1'b0;
        if (cfg.key_enable[KEY_T])
        begin
            ev_t           = t_active && !t_pressed_reg;
            t_pressed_next = t_active;
        end
    end

    // B key: learned idle level, debounce window between shorts
    always_comb
    begin
        b_idle_known_next = b_idle_known_reg;
        b_idle_level_next = b_idle_level_reg;
        b_pressed_next    = b_pressed_reg;
        b_short_seen_next = b_short_seen_reg;
        b_since_next      = since_inc;
        ev_b              = 1'b0;
        if (!cfg.key_enable[KEY_B])
        begin
            b_pressed_next = 1'b0;
        end
        else if (!b_idle_known_reg)
        begin
            b_idle_level_next = b_level;
            b_idle_known_next = 1'b1;
            b_pressed_next    = 1'b0;
        end
        else if (b_level == b_idle_level_reg)
        begin
            b_pressed_next = 1'b0;
        end
        else if (!b_pressed_reg && (!b_short_seen_reg || debounce_over))
        begin
            b_short_seen_next = 1'b1;
            b_since_next      = '0;
            b_pressed_next    = 1'b1;
            ev_b              = 1'b1;
        end
    end

    // State update on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_pressed_reg   <= 1'b0;
            power_long_done_reg <= 1'b0;
            power_hold_reg      <= '0;
            t_pressed_reg       <= 1'b0;
            b_idle_known_reg    <= 1'b0;
            b_idle_level_reg    <= 1'b0;
            b_pressed_reg       <= 1'b0;
            b_short_seen_reg    <= 1'b0;
            b_since_reg         <= '0;
        end
        else if (accept)
        begin
            power_pressed_reg   <= power_pressed_next;
            power_long_done_reg <= power_long_done_next;
            power_hold_reg      <= power_hold_next;
            t_pressed_reg       <= t_pressed_next;
            b_idle_known_reg    <= b_idle_known_next;
            b_idle_level_reg    <= b_idle_level_next;
            b_pressed_reg       <= b_pressed_next;
            b_short_seen_reg    <= b_short_seen_next;
            b_since_reg         <= b_since_next;
        end
    end

endmodule

### hdl/tkpeq_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpeq_out_skid
// Two-entry result buffer: a head register driving the port and a spare
// register that soaks up one more beat while the receiver stalls.
// ----------------------------------------------------------------------------
module tkpeq_out_skid
    import tkpeq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tkpeq_events_t push_data,
    output logic          can_push,
    output logic          head_valid,
    input  logic          pop,
    output tkpeq_events_t head_data
);

    logic [1:0]    count_reg, count_next;
    tkpeq_events_t head_reg,  head_next;
    tkpeq_events_t spare_reg, spare_next;
    logic          do_pop;

    assign do_pop     = pop && (count_reg != 2'd0);
    assign can_push   = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = head_reg;

    // Occupancy and data movement
    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, do_pop};
        head_next  = head_reg;
        spare_next = spare_reg;
        if (do_pop)
        begin
            if (count_reg == 2'd2)
                head_next = spare_reg;
            else if (push)
                head_next = push_data;
        end
        else if (push && (count_reg == 2'd0))
        begin
            head_next = push_data;
        end
        if (push && (((count_reg == 2'd1) && !do_pop) || ((count_reg == 2'd2) && do_pop)))
            spare_next = push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

endmodule

### hdl/three_key_press_event_qualifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_key_press_event_qualifier_core
// Qualifies power, B and T key samples into press / short / long events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sample beat: the three
//   key pin levels and a flag that a millisecond tick elapsed.
//   Output channel (out_valid/out_ready) returns one event mask per sample.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the four registers; cfg_ready is always high. Write only while idle.
// Latency: a result is offered the cycle after its sample if none is ahead.
// Throughput: one sample per cycle while in_ready is high; key state
//   updates in one logic pass between accepted beat and result buffer.
// Stall: a two-entry result buffer keeps in_ready high while one result
//   waits; in_ready drops only when both entries are full.
// Reset: all key state is cleared, registers return to their defaults
//   (1500 ticks, 220 ticks, active high, all keys enabled), buffer empty.
// ----------------------------------------------------------------------------
module three_key_press_event_qualifier_core
    import tkpeq_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  power_level,
    input  logic                  b_level,
    input  logic                  t_level,
    input  logic                  tick,
    // event channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  power_press,
    output logic                  power_short,
    output logic                  power_long,
    output logic                  b_short,
    output logic                  t_short,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    tkpeq_cfg_t    cfg_reg;
    tkpeq_events_t events;
    tkpeq_events_t head;
    logic          accept;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= LONG_PRESS_TICKS_RST;
            cfg_reg.b_gap_ticks      <= B_GAP_TICKS_RST;
            cfg_reg.press_level      <= PRESS_LEVEL_RST;
            cfg_reg.key_enable       <= KEY_ENABLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_data;
                REG_B_GAP_TICKS:      cfg_reg.b_gap_ticks      <= cfg_data;
                REG_PRESS_LEVEL:      cfg_reg.press_level      <= cfg_data[0];
                REG_KEY_ENABLE:       cfg_reg.key_enable       <= cfg_data[KEY_EN_W-1:0];
                default:              ;
            endcase
        end
    end

    // Key state and event decode
    tkpeq_event_logic #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_event_logic (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .power_level (power_level),
        .b_level     (b_level),
        .t_level     (t_level),
        .tick        (tick),
        .cfg         (cfg_reg),
        .events      (events)
    );

    // Result buffer
    tkpeq_out_skid u_out_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (events),
        .can_push   (in_ready),
        .head_valid (out_valid),
        .pop        (out_ready),
        .head_data  (head)
    );

    assign power_press = head.power_press;
    assign power_short = head.power_short;
    assign power_long  = head.power_long;
    assign b_short     = head.b_short;
    assign t_short     = head.t_short;

endmodule

### hdl/tkpeq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkpeq_checker
// Port-level checks for the key event qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module tkpeq_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic power_press,
    input logic power_short,
    input logic power_long
);

    // Power events are mutually exclusive within one beat
    a_power_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones({power_press, power_short, power_long}) <= 1))
        else $error("more than one power event in a beat");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(power_press) && $stable(power_short)
             && $stable(power_long)))
        else $error("stalled result beat changed");

    // Empty buffer never back-pressures the sample side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with no result pending");

    // Long fires once per hold, never in two consecutive beats
    a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && power_long) |=> !(out_valid && power_long))
        else $error("power_long in consecutive beats");

endmodule

bind three_key_press_event_qualifier_core tkpeq_checker u_tkpeq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .power_press (power_press),
    .power_short (power_short),
    .power_long  (power_long)
);
